// ===== src/eecq_pkg.sv =====
// Package with shared constants and control types for the earliest-expiry queue.
`timescale 1ns / 1ps
package eecq_pkg;
	localparam int HEAP_DEPTH = 64;
	localparam int IDX_W = $clog2(HEAP_DEPTH);
	localparam int SIZE_W = $clog2(HEAP_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INSERT,   // open a hole at heap_size for the new entry, start sift up
		OP_POP,      // move last entry to root, start sift down
		OP_DEC,      // decrement root credits
		OP_FINISH    // advance tick, capture result word
	} op_t;

	typedef struct packed {
		op_t  op;
		logic step;  // do one sift step
		logic up;    // not read; the datapath keeps its own sift direction
		logic load;  // latch input word
	} cmd_t;

	typedef struct packed {
		logic busy;      // sift in progress
		logic empty;
		logic full;
		logic root_dead; // root expired or used up
		logic root_last; // root has one credit
		logic has_count;
	} stat_t;
endpackage

// ===== src/eecq_datapath.sv =====
// Heap storage, sift engine, tick counter and running total.
`timescale 1ns / 1ps
module eecq_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  eecq_pkg::cmd_t         cmd,
	input  logic [15:0]            new_count,
	input  logic [15:0]            lifetime,
	output eecq_pkg::stat_t        stat,
	output logic [31:0]            total_q
);
	localparam int IW = eecq_pkg::IDX_W;
	localparam int SW = eecq_pkg::SIZE_W;

	// Sift phases: fetch the moved entry after a pop, present read addresses, compare.
	typedef enum logic [1:0] {PH_ADDR, PH_CMP, PH_LOAD} phase_t;

	// Heap entries are packed as {expiry, credits}. The entry being sifted is held in
	// a register and only the hole it leaves behind is written, once per level.
	logic [47:0] heap_mem [eecq_pkg::HEAP_DEPTH];
	logic [47:0] rd_a_q, rd_b_q;
	logic [47:0] root_q;  // copy of entry zero, kept in step with every write there
	logic [47:0] mov_q;
	logic [SW-1:0] size_q;
	logic [31:0] tick_q;
	logic [15:0] count_q, life_q;
	logic [IW-1:0] hole_q;
	logic busy_q, up_q;
	phase_t phase_q;

	logic [IW-1:0] par, lft, rgt, rd_a_addr, rd_b_addr, wr_addr;
	logic [SW:0] lft_w, rgt_w;
	logic lft_ok, rgt_ok, take_lft, take_rgt;
	logic [32:0] exp_sum;
	logic [31:0] new_exp;
	logic [SW-1:0] last;
	logic do_step, wr_en;
	logic [47:0] wr_data;

	assign par = (hole_q - IW'(1)) >> 1;
	assign lft_w = (SW+1)'({hole_q, 1'b1});
	assign rgt_w = lft_w + (SW+1)'(1);
	assign lft = lft_w[IW-1:0];
	assign rgt = rgt_w[IW-1:0];
	assign lft_ok = (SW+1)'(size_q) > lft_w;
	assign rgt_ok = (SW+1)'(size_q) > rgt_w;
	assign take_lft = lft_ok && (rd_a_q[47:16] < mov_q[47:16]);
	assign take_rgt = rgt_ok &&
		(rd_b_q[47:16] < (take_lft ? rd_a_q[47:16] : mov_q[47:16]));
	assign exp_sum = {1'b0, tick_q} + 33'(life_q);
	assign new_exp = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
	assign last = size_q - SW'(1);
	assign do_step = cmd.step && busy_q;

	// Port A fetches the last entry on a pop, the parent when climbing and the left
	// child when sinking; port B always fetches the right child.
	assign rd_a_addr = (cmd.op == eecq_pkg::OP_POP) ? last[IW-1:0] : (up_q ? par : lft);
	assign rd_b_addr = rgt;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = hole_q;
		wr_data = mov_q;
		case (cmd.op)
			eecq_pkg::OP_DEC: begin
				wr_en = 1'b1;
				wr_addr = '0;
				wr_data = {root_q[47:16], root_q[15:0] - 16'd1};
			end
			default: ;
		endcase
		if (do_step) begin
			if (up_q) begin
				if (phase_q == PH_ADDR && hole_q == '0) begin
					wr_en = 1'b1;
				end else if (phase_q == PH_CMP) begin
					wr_en = 1'b1;
					wr_data = (rd_a_q[47:16] > mov_q[47:16]) ? rd_a_q : mov_q;
				end
			end else if (phase_q == PH_CMP) begin
				wr_en = 1'b1;
				wr_data = take_rgt ? rd_b_q : (take_lft ? rd_a_q : mov_q);
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.empty = (size_q == '0);
	assign stat.full = (size_q == SW'(eecq_pkg::HEAP_DEPTH));
	assign stat.root_dead = (root_q[47:16] <= tick_q) || (root_q[15:0] == '0);
	assign stat.root_last = (root_q[15:0] == 16'd1);
	assign stat.has_count = (count_q != '0);

	always_ff @(posedge clk) begin
		if (wr_en)
			heap_mem[wr_addr] <= wr_data;
		rd_a_q <= heap_mem[rd_a_addr];
		rd_b_q <= heap_mem[rd_b_addr];
		if (cmd.load) begin
			count_q <= new_count;
			life_q <= lifetime;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			tick_q <= 32'd1;
			total_q <= '0;
			busy_q <= 1'b0;
			up_q <= 1'b0;
			hole_q <= '0;
			phase_q <= PH_ADDR;
			mov_q <= '0;
			root_q <= '0;
		end else begin
			if (wr_en && wr_addr == '0)
				root_q <= wr_data;
			case (cmd.op)
				eecq_pkg::OP_INSERT: begin
					mov_q <= {new_exp, count_q};
					hole_q <= size_q[IW-1:0];
					size_q <= size_q + SW'(1);
					up_q <= 1'b1;
					busy_q <= 1'b1;
					phase_q <= PH_ADDR;
				end
				eecq_pkg::OP_POP: begin
					hole_q <= '0;
					size_q <= last;
					up_q <= 1'b0;
					phase_q <= PH_LOAD;
					busy_q <= (last != '0);
				end
				eecq_pkg::OP_DEC: begin
					if (total_q != 32'hFFFF_FFFF)
						total_q <= total_q + 32'd1;
				end
				eecq_pkg::OP_FINISH: begin
					if (tick_q != 32'hFFFF_FFFF)
						tick_q <= tick_q + 32'd1;
				end
				default: ;
			endcase
			if (do_step) begin
				case (phase_q)
					// The children of the root were fetched in this same cycle.
					PH_LOAD: begin
						mov_q <= rd_a_q;
						phase_q <= PH_CMP;
					end
					PH_ADDR: begin
						if (up_q && hole_q == '0)
							busy_q <= 1'b0;
						else
							phase_q <= PH_CMP;
					end
					PH_CMP: begin
						phase_q <= PH_ADDR;
						if (up_q) begin
							if (rd_a_q[47:16] > mov_q[47:16])
								hole_q <= par;
							else
								busy_q <= 1'b0;
						end else if (take_rgt) begin
							hole_q <= rgt;
						end else if (take_lft) begin
							hole_q <= lft;
						end else begin
							busy_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== src/eecq_ctrl.sv =====
// Sequencer that runs insert, expiry pops and consumption for one tick.
`timescale 1ns / 1ps
module eecq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            out_fire,
	input  eecq_pkg::stat_t stat,
	output eecq_pkg::cmd_t  cmd,
	output logic            idle,
	output logic            res_valid_q,
	output logic            consumed_q,
	output logic            dropped_q
);
	typedef enum logic [2:0] {
		S_IDLE, S_INS, S_SIFT, S_PURGE, S_USE, S_LAST, S_DONE
	} state_t;
	state_t state_q;
	logic purge_q; // sift belongs to purge phase
	logic done_go; // output register is free for the finished tick

	assign idle = (state_q == S_IDLE);
	assign done_go = !res_valid_q || out_fire;

	always_comb begin
		cmd = '{op: eecq_pkg::OP_NONE, step: 1'b0, up: 1'b0, load: 1'b0};
		cmd.load = in_fire;
		case (state_q)
			S_INS: if (stat.has_count && !stat.full) cmd.op = eecq_pkg::OP_INSERT;
			S_SIFT: cmd.step = stat.busy;
			S_PURGE: if (!stat.empty && stat.root_dead) cmd.op = eecq_pkg::OP_POP;
			S_USE: if (!stat.empty) cmd.op = eecq_pkg::OP_DEC;
			S_LAST: if (!stat.empty && stat.root_dead) cmd.op = eecq_pkg::OP_POP;
			S_DONE: if (done_go) cmd.op = eecq_pkg::OP_FINISH;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			purge_q <= 1'b0;
			res_valid_q <= 1'b0;
			consumed_q <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && done_go)
				res_valid_q <= 1'b1;
			else if (out_fire)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_INS;
				S_INS: begin
					dropped_q <= stat.has_count && stat.full;
					consumed_q <= 1'b0;
					purge_q <= 1'b1;
					state_q <= S_SIFT;
				end
				S_SIFT: if (!stat.busy) state_q <= purge_q ? S_PURGE : S_DONE;
				S_PURGE: begin
					if (!stat.empty && stat.root_dead) state_q <= S_SIFT;
					else state_q <= S_USE;
				end
				S_USE: begin
					consumed_q <= !stat.empty;
					state_q <= stat.empty ? S_DONE : S_LAST;
				end
				S_LAST: begin
					purge_q <= 1'b0;
					state_q <= S_SIFT;
				end
				S_DONE: if (done_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/earliest_expiry_consume_queue.sv =====
// Top level of the earliest-expiry credit queue.
`timescale 1ns / 1ps
// Usage: each word accepted on the s_axis side is one tick. tdata carries
// new_count and lifetime; a nonzero count adds a batch expiring at the current
// tick plus its lifetime into a min-heap ordered by expiry. The tick then drops
// batches at the top that have expired or are used up, consumes one credit from
// the earliest batch, and returns one result word on m_axis.
// Time to m_axis_tvalid grows with the work done: an insert sift climbs the heap,
// and each removal, in the purge loop or of the batch just used up, sinks the
// moved entry. Every heap level costs an address step and a compare step because
// the heap memory is read through registered ports.
// One tick is worked at a time; s_axis_tready is high only while the controller
// is idle. A new word may be accepted while the previous result still waits in
// the output register; that tick then holds at its last step until the receiver
// takes the older word, so a stalled receiver stalls the input after one tick.
// Reset (arst_n low) empties the heap, sets the tick to one and the running
// total to zero; no clearing pass is needed because only live entries are read.
module earliest_expiry_consume_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] new_count, [31:16] lifetime
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] consumed, [32:1] total_consumed, [33] queue_empty, [34] batch_dropped
	output logic [39:0] m_axis_tdata
);
	eecq_pkg::cmd_t  cmd;
	eecq_pkg::stat_t stat;
	logic idle, consumed, dropped;
	logic [31:0] total;
	logic in_fire, out_fire;
	logic [34:0] res_q;

	assign s_axis_tready = idle;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	eecq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.stat(stat), .cmd(cmd), .idle(idle), .res_valid_q(m_axis_tvalid),
		.consumed_q(consumed), .dropped_q(dropped)
	);

	eecq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.new_count(s_axis_tdata[15:0]), .lifetime(s_axis_tdata[31:16]),
		.stat(stat), .total_q(total)
	);

	// The result word is captured when the tick finishes, so the next tick can run
	// while it waits for the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (cmd.op == eecq_pkg::OP_FINISH) begin
			res_q <= {dropped, stat.empty, total, consumed};
		end
	end

	assign m_axis_tdata = {5'd0, res_q};
endmodule

// ===== src/eecq_checker.sv =====
// Port-level checker for the earliest-expiry queue, bound to the top level.
`timescale 1ns / 1ps
module eecq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("tick not in progress after accept");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
		else $error("padding bits of result word not zero");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[32:1] != 32'd0)
		else $error("consumed with zero total");
endmodule

bind earliest_expiry_consume_queue eecq_checker u_eecq_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== dv/earliest_expiry_consume_queue_checker.sv =====
// Checker that predicts and compares every result word of the earliest-expiry queue.
`timescale 1ns / 1ps
module earliest_expiry_consume_queue_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	output int          fail_count,
	output int          pending_results,
	output int          results_seen,
	output int          drops_seen,
	output int          consumed_seen
);
	typedef struct packed {
		logic        consumed;
		logic [31:0] total;
		logic        empty;
		logic        dropped;
	} tick_result_t;

	logic [31:0]  batch_exp [eecq_pkg::HEAP_DEPTH];
	logic [15:0]  batch_left [eecq_pkg::HEAP_DEPTH];
	int           batch_cnt;
	logic [31:0]  cur_tick;
	logic [31:0]  used_total;
	tick_result_t expected_results [$];

	function automatic void swap_batches(int a, int b);
		logic [31:0] e;
		logic [15:0] r;
		e = batch_exp[a];
		r = batch_left[a];
		batch_exp[a] = batch_exp[b];
		batch_left[a] = batch_left[b];
		batch_exp[b] = e;
		batch_left[b] = r;
	endfunction

	function automatic void remove_root();
		int i;
		int l;
		int best;
		if (batch_cnt == 0)
			return;
		batch_cnt--;
		if (batch_cnt == 0)
			return;
		batch_exp[0] = batch_exp[batch_cnt];
		batch_left[0] = batch_left[batch_cnt];
		i = 0;
		forever begin
			l = 2 * i + 1;
			best = i;
			if (l < batch_cnt && batch_exp[l] < batch_exp[best])
				best = l;
			if (l + 1 < batch_cnt && batch_exp[l + 1] < batch_exp[best])
				best = l + 1;
			if (best == i)
				break;
			swap_batches(best, i);
			i = best;
		end
	endfunction

	// Works out one tick: insert, drop dead batches, take one credit.
	function automatic tick_result_t run_tick(logic [15:0] cnt, logic [15:0] life);
		tick_result_t r;
		logic [32:0] sum;
		int i;
		r = '0;
		if (cnt != 0) begin
			if (batch_cnt >= eecq_pkg::HEAP_DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				sum = {1'b0, cur_tick} + 33'(life);
				i = batch_cnt;
				batch_exp[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				batch_left[i] = cnt;
				batch_cnt++;
				while (i > 0 && batch_exp[(i - 1) / 2] > batch_exp[i]) begin
					swap_batches((i - 1) / 2, i);
					i = (i - 1) / 2;
				end
			end
		end
		while (batch_cnt > 0 && (batch_exp[0] <= cur_tick || batch_left[0] == 0))
			remove_root();
		if (batch_cnt > 0) begin
			r.consumed = 1'b1;
			if (used_total != 32'hFFFF_FFFF)
				used_total++;
			batch_left[0]--;
			if (batch_left[0] == 0)
				remove_root();
		end
		if (cur_tick != 32'hFFFF_FFFF)
			cur_tick++;
		r.total = used_total;
		r.empty = (batch_cnt == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		tick_result_t got;
		if (!arst_n) begin
			batch_cnt = 0;
			cur_tick = 32'd1;
			used_total = '0;
			fail_count <= 0;
			pending_results <= 0;
			results_seen <= 0;
			drops_seen <= 0;
			consumed_seen <= 0;
			expected_results.delete();
		end else begin
			pending_results <= pending_results + ((s_axis_tvalid && s_axis_tready) ? 1 : 0)
				- ((m_axis_tvalid && m_axis_tready) ? 1 : 0);
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(run_tick(s_axis_tdata[15:0], s_axis_tdata[31:16]));
			if (m_axis_tvalid && m_axis_tready) begin
				got.consumed = m_axis_tdata[0];
				got.total = m_axis_tdata[32:1];
				got.empty = m_axis_tdata[33];
				got.dropped = m_axis_tdata[34];
				results_seen <= results_seen + 1;
				drops_seen <= drops_seen + got.dropped;
				consumed_seen <= consumed_seen + got.consumed;
				if (expected_results.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("ERROR: result word with no tick pending: %h", m_axis_tdata);
				end else begin
					want = expected_results.pop_front();
					if (want !== got) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display({"ERROR: result %0d expected c=%b t=%0d e=%b d=%b,",
								" got c=%b t=%0d e=%b d=%b"},
								results_seen, want.consumed, want.total, want.empty,
								want.dropped, got.consumed, got.total, got.empty,
								got.dropped);
					end
				end
			end
		end
	end
endmodule

// ===== dv/earliest_expiry_consume_queue_tb.sv =====
// Testbench top that drives ticks into the earliest-expiry queue and reports the verdict.
`timescale 1ns / 1ps
module earliest_expiry_consume_queue_tb;
	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	int          fail_count;
	int          pending_results;
	int          results_seen;
	int          drops_seen;
	int          consumed_seen;
	int          idle_cycles;
	int          hold_off;
	bit          fill_phase;
	bit          hold_used;

	localparam int WATCHDOG_LIMIT = 20000;

	earliest_expiry_consume_queue u_top (.*);

	earliest_expiry_consume_queue_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Offers one tick word and returns after the edge that accepts it; valid stays
	// high so back-to-back calls send words without a gap.
	task automatic send_tick(input logic [15:0] cnt, input logic [15:0] life);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {life, cnt};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Drops valid for a gap set by n; a zero n leaves the input as it is.
	task automatic gap(input int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// A random tick: mostly small lifetimes and counts so batches live and die in
	// the run, with some full-range values mixed in.
	task automatic random_tick();
		logic [15:0] c;
		logic [15:0] l;
		case ($urandom_range(0, 9))
			0, 1: c = 16'd0;
			2: c = 16'($urandom);
			default: c = 16'($urandom_range(1, 6));
		endcase
		case ($urandom_range(0, 9))
			0: l = 16'($urandom);
			1: l = 16'd0;
			default: l = 16'($urandom_range(1, 40));
		endcase
		send_tick(c, l);
	endtask

	// Receiver stalls on its own pattern, plus one long hold-off while the heap fills.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_off <= 0;
			hold_used <= 1'b0;
		end else if (fill_phase && !hold_used) begin
			hold_off <= 300;
			hold_used <= 1'b1;
			m_axis_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else if (results_seen < 100 || (results_seen / 128) % 2 == 1) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Watchdog over cycles in which no word moves on either side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int burst;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		fill_phase = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, zero count, zero lifetime.
		send_tick(16'd0, 16'hFFFF);
		gap(1);
		send_tick(16'hFFFF, 16'd0);
		gap(1);
		send_tick(16'd1, 16'd1);
		gap(1);
		send_tick(16'd0, 16'd0);
		gap(1);
		send_tick(16'hFFFF, 16'hFFFF);
		gap(1);
		send_tick(16'd2, 16'd3);
		send_tick(16'd2, 16'd3);
		send_tick(16'h5555, 16'hAAAA);
		send_tick(16'hAAAA, 16'h5555);
		gap(1);
		send_tick(16'd0, 16'd0);
		gap(1);

		// Fill the heap well past its depth to force dropped batches, while the
		// receiver holds off so the block stalls its input. These batches expire
		// early in the random phase so the heap drains again.
		fill_phase = 1'b1;
		for (int i = 0; i < eecq_pkg::HEAP_DEPTH + 8; i++)
			send_tick(16'd100, 16'd90 + 16'(i));
		gap(1);
		wait (pending_results == 0);
		@(posedge clk);

		// Random ticks in bursts with random gaps.
		for (int n = 0; n < 720; ) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst; k++)
				random_tick();
			n += burst;
			if (n > 360 && n - burst <= 360) begin
				gap(1);
				wait (pending_results == 0);
			end
			gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20));
		end
		gap(1);

		wait (pending_results == 0);
		gap(100);
		$display("Run covered %0d result words, %0d credits consumed, %0d batches dropped.",
			results_seen, consumed_seen, drops_seen);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
